/* sv/bbse_pkg.sv */
package bbse_pkg;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QueueDepthDef = 4;

  // Reset value of the step register, Q1.15.
  localparam logic [15:0] StepReset = 16'd55;

  // One in Q1.15, on 17 bits so that it can be held.
  localparam logic [16:0] OneQ15 = 17'd32768;

  // Number of control points and the highest valid slot.
  localparam int unsigned NumPoints = 9;
  localparam logic [3:0] MaxSlot = 4'd8;

  // Opcodes of an input word.
  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  // Q4.12 constants used by the default patch.
  localparam logic [15:0] PosOne  = 16'h1000;
  localparam logic [15:0] NegOne  = 16'hF000;
  localparam logic [15:0] PosHalf = 16'h0800;
  localparam logic [15:0] Zero16  = 16'h0000;

  // A point: element 0 is x, 1 is y, 2 is z, each Q4.12 two's complement.
  typedef logic [2:0][15:0] point_t;

  // A word as it travels through the queue.
  typedef struct packed {
    logic        op;
    logic [3:0]  idx;
    point_t      pt;
    logic [16:0] u;
    logic [16:0] v;
    logic [16:0] un;
    logic [16:0] vn;
  } item_t;

  // Reset contents of the control point store.
  function automatic point_t default_point(input logic [3:0] idx);
    point_t p;
    case (idx)
      4'd0: p = {NegOne, PosOne, NegOne};
      4'd1: p = {NegOne, Zero16, Zero16};
      4'd2: p = {NegOne, Zero16, PosOne};
      4'd3: p = {Zero16, PosHalf, NegOne};
      4'd4: p = {Zero16, PosOne, Zero16};
      4'd5: p = {Zero16, PosHalf, PosOne};
      4'd6: p = {PosOne, Zero16, NegOne};
      4'd7: p = {PosOne, NegOne, Zero16};
      4'd8: p = {PosOne, Zero16, PosOne};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* sv/bbse_if.sv */
interface bbse_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] step_size;
  modport source (output valid, output step_size, input ready);
  modport sink (input valid, input step_size, output ready);
endinterface

interface bbse_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [3:0]         point_index;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [15:0]        u_param;
  logic [15:0]        v_param;
  modport source (output valid, output opcode, output point_index, output coord_x,
                  output coord_y, output coord_z, output u_param, output v_param,
                  input ready);
  modport sink (input valid, input opcode, input point_index, input coord_x,
                input coord_y, input coord_z, input u_param, input v_param,
                output ready);
endinterface

interface bbse_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               normal_valid;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output normal_x, output normal_y, output normal_z,
                  output normal_valid, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input normal_x, input normal_y, input normal_z,
                input normal_valid, output ready);
endinterface

/* sv/bbse_front.sv */
module bbse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  bbse_cfg_if.sink        cfg_i,
  bbse_in_if.sink         req_i,
  input  logic            full_i,
  output logic            push_o,
  output bbse_pkg::item_t item_o
);
  import bbse_pkg::*;

  logic [15:0] step_q, step_d;
  logic [16:0] u_c, v_c;
  logic [17:0] u_sum, v_sum;
  logic        bad_load;

  function automatic logic [16:0] clamp_one(input logic [17:0] val);
    logic [16:0] res;
    res = (val > {1'b0, OneQ15}) ? OneQ15 : val[16:0];
    return res;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign step_d = cfg_i.valid ? cfg_i.step_size : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else begin
      step_q <= step_d;
    end
  end

  // Clamp the parameters and form the neighbour parameters.
  always_comb begin
    u_c   = clamp_one({2'b00, req_i.u_param});
    v_c   = clamp_one({2'b00, req_i.v_param});
    u_sum = {1'b0, u_c} + {2'b00, step_q};
    v_sum = {1'b0, v_c} + {2'b00, step_q};
  end

  // Loads to a slot outside the grid are taken and dropped here.
  assign bad_load = (req_i.opcode == OpLoad) && (req_i.point_index > MaxSlot);

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i && !bad_load;

  always_comb begin
    item_o.op  = req_i.opcode;
    item_o.idx = req_i.point_index;
    item_o.pt  = {req_i.coord_z, req_i.coord_y, req_i.coord_x};
    item_o.u   = u_c;
    item_o.v   = v_c;
    item_o.un  = clamp_one(u_sum);
    item_o.vn  = clamp_one(v_sum);
  end

endmodule

/* sv/bbse_fifo.sv */
module bbse_fifo #(
  parameter int unsigned Depth = bbse_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bbse_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bbse_pkg::item_t item_o
);
  import bbse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* sv/bbse_back.sv */
module bbse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  bbse_pkg::item_t item_i,
  output logic            pop_o,
  bbse_out_if.source      rsp_o
);
  import bbse_pkg::*;

  localparam int unsigned SqSteps  = 32;
  localparam int unsigned DivSteps = 16;

  typedef struct packed {
    point_t     pos;
    logic [2:0] neg;
    logic       zero;
  } tag_t;

  logic adv;

  point_t [NumPoints-1:0] store_q;

  // Valid bits of the fixed stages, the root chain and the divider chain.
  logic [8:0]        vld_q;
  logic [SqSteps:0]  sq_vld_q;
  logic [DivSteps:0] dv_vld_q;
  logic              out_vld_q;

  // Stage payloads.
  logic [3:0][16:0]             t1_q;
  point_t [NumPoints-1:0]       pts1_q, pts2_q;
  logic [3:0][2:0][30:0]        w2_q, w2_d;
  point_t [1:0][2:0]            row3_q, row3_d;
  logic [1:0][2:0][30:0]        wv3_q;
  point_t [2:0]                 vec4_q, vec4_d;
  logic [2:0][34:0]             cr5_q, cr5_d;
  point_t                       pos5_q, pos6_q, pos7_q;
  logic [2:0][33:0]             mag6_q, mag6_d, mag7_q;
  logic [2:0]                   neg6_q, neg7_q;
  logic [33:0]                  or6_q;
  logic [5:0]                   lead7_q, lead7_d;
  logic                         zero7_q;
  logic [2:0][30:0]             nm8_q, nm8_d, nm9_q;
  tag_t                         tag8_q, tag9_q;
  logic [2:0][61:0]             sqr9_q, sqr9_d;

  logic [63:0]      sq_rem_q [SqSteps+1];
  logic [63:0]      sq_res_q [SqSteps+1];
  logic [2:0][30:0] sq_nm_q  [SqSteps+1];
  tag_t             sq_tag_q [SqSteps+1];
  logic [63:0]      sq_rem_d [SqSteps+1];
  logic [63:0]      sq_res_d [SqSteps+1];

  logic [2:0][31:0] dv_rem_q [DivSteps+1];
  logic [2:0][15:0] dv_num_q [DivSteps+1];
  logic [2:0][15:0] dv_quo_q [DivSteps+1];
  logic [31:0]      dv_len_q [DivSteps+1];
  tag_t             dv_tag_q [DivSteps+1];
  logic [2:0][31:0] dv_rem_d [DivSteps+1];
  logic [2:0][15:0] dv_quo_d [DivSteps+1];
  logic [2:0][45:0] dv_n0;

  point_t      out_pos_q;
  logic [2:0][15:0] out_nrm_q, out_nrm_d;
  logic        out_nv_q;

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c, input logic [30:0] w0,
                                        input logic [30:0] w1, input logic [30:0] w2);
    logic signed [47:0] acc;
    acc = $signed({1'b0, w0}) * $signed(a) + $signed({1'b0, w1}) * $signed(b)
        + $signed({1'b0, w2}) * $signed(c) + 48'sd536870912;
    return acc[45:30];
  endfunction

  // The whole pipeline moves when the output register is free or being emptied.
  assign adv   = !out_vld_q || rsp_o.ready;
  assign pop_o = adv && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPoints; i++) begin
        store_q[i] <= default_point(4'(i));
      end
      vld_q     <= '0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o && (item_i.op == OpLoad)) begin
        store_q[item_i.idx] <= item_i.pt;
      end
      if (adv) begin
        vld_q     <= {vld_q[7:0], pop_o && (item_i.op == OpEval)};
        sq_vld_q  <= {sq_vld_q[SqSteps-1:0], vld_q[8]};
        dv_vld_q  <= {dv_vld_q[DivSteps-1:0], sq_vld_q[SqSteps]};
        out_vld_q <= dv_vld_q[DivSteps];
      end
    end
  end

  // Blend weights (1-t)^2, 2(1-t)t and t^2 in Q2.30 for u, u+step, v, v+step.
  always_comb begin
    logic [16:0] it;
    logic [33:0] p0, p1, p2;
    for (int i = 0; i < 4; i++) begin
      it = OneQ15 - t1_q[i];
      p0 = 34'(it) * 34'(it);
      p1 = 34'(it) * 34'(t1_q[i]);
      p2 = 34'(t1_q[i]) * 34'(t1_q[i]);
      w2_d[i][0] = p0[30:0];
      w2_d[i][1] = {p1[29:0], 1'b0};
      w2_d[i][2] = p2[30:0];
    end
  end

  // Row blends in u and in u+step.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          row3_d[p][r][k] = blend(pts2_q[r*3][k], pts2_q[r*3+1][k], pts2_q[r*3+2][k],
                                  w2_q[p][0], w2_q[p][1], w2_q[p][2]);
        end
      end
    end
  end

  // Column blends: the point, its u neighbour and its v neighbour.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec4_d[0][k] = blend(row3_q[0][0][k], row3_q[0][1][k], row3_q[0][2][k],
                           wv3_q[0][0], wv3_q[0][1], wv3_q[0][2]);
      vec4_d[1][k] = blend(row3_q[1][0][k], row3_q[1][1][k], row3_q[1][2][k],
                           wv3_q[0][0], wv3_q[0][1], wv3_q[0][2]);
      vec4_d[2][k] = blend(row3_q[0][0][k], row3_q[0][1][k], row3_q[0][2][k],
                           wv3_q[1][0], wv3_q[1][1], wv3_q[1][2]);
    end
  end

  // Cross product of the two tangent differences.
  always_comb begin
    logic signed [34:0] du [3];
    logic signed [34:0] dv [3];
    for (int k = 0; k < 3; k++) begin
      du[k] = 35'($signed(vec4_q[1][k])) - 35'($signed(vec4_q[0][k]));
      dv[k] = 35'($signed(vec4_q[2][k])) - 35'($signed(vec4_q[0][k]));
    end
    cr5_d[0] = dv[1] * du[2] - dv[2] * du[1];
    cr5_d[1] = dv[2] * du[0] - dv[0] * du[2];
    cr5_d[2] = dv[0] * du[1] - dv[1] * du[0];
  end

  // Magnitudes, and the position of the leading one over all three of them.
  always_comb begin
    logic [34:0] a;
    for (int k = 0; k < 3; k++) begin
      a = cr5_q[k][34] ? (~cr5_q[k] + 35'd1) : cr5_q[k];
      mag6_d[k] = a[33:0];
    end
    lead7_d = '0;
    for (int b = 0; b < 34; b++) begin
      if (or6_q[b]) begin
        lead7_d = 6'(b);
      end
    end
  end

  // Scale so that the largest magnitude lies in [2^30, 2^31).
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (lead7_q > 6'd30) begin
        nm8_d[k] = 31'(mag7_q[k] >> (lead7_q - 6'd30));
      end else begin
        nm8_d[k] = 31'(mag7_q[k] << (6'd30 - lead7_q));
      end
      sqr9_d[k] = 62'(nm8_q[k]) * 62'(nm8_q[k]);
    end
  end

  // Square root, one result bit per stage.
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_rem_d[0] = 64'(sqr9_q[0]) + 64'(sqr9_q[1]) + 64'(sqr9_q[2]);
    sq_res_d[0] = '0;
    for (int i = 0; i < SqSteps; i++) begin
      bitv  = 64'd1 << (62 - 2 * i);
      trial = sq_res_q[i] + bitv;
      if (sq_rem_q[i] >= trial) begin
        sq_rem_d[i+1] = sq_rem_q[i] - trial;
        sq_res_d[i+1] = (sq_res_q[i] >> 1) + bitv;
      end else begin
        sq_rem_d[i+1] = sq_rem_q[i];
        sq_res_d[i+1] = sq_res_q[i] >> 1;
      end
    end
  end

  // Rounded division of each scaled magnitude by the length, one bit per stage.
  always_comb begin
    logic [32:0] r;
    for (int k = 0; k < 3; k++) begin
      dv_n0[k] = {1'b0, sq_nm_q[SqSteps][k], 14'd0} + 46'(sq_res_q[SqSteps][31:1]);
      dv_rem_d[0][k] = 32'(dv_n0[k][45:16]);
      dv_quo_d[0][k] = '0;
    end
    for (int j = 0; j < DivSteps; j++) begin
      for (int k = 0; k < 3; k++) begin
        r = {dv_rem_q[j][k], dv_num_q[j][k][15-j]};
        if (r >= {1'b0, dv_len_q[j]}) begin
          dv_rem_d[j+1][k] = 32'(r - {1'b0, dv_len_q[j]});
          dv_quo_d[j+1][k] = {dv_quo_q[j][k][14:0], 1'b1};
        end else begin
          dv_rem_d[j+1][k] = r[31:0];
          dv_quo_d[j+1][k] = {dv_quo_q[j][k][14:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_tag_q[DivSteps].zero) begin
        out_nrm_d[k] = '0;
      end else if (dv_tag_q[DivSteps].neg[k]) begin
        out_nrm_d[k] = ~dv_quo_q[DivSteps][k] + 16'd1;
      end else begin
        out_nrm_d[k] = dv_quo_q[DivSteps][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q   <= {item_i.vn, item_i.v, item_i.un, item_i.u};
      pts1_q <= store_q;
      w2_q   <= w2_d;
      pts2_q <= pts1_q;
      row3_q <= row3_d;
      wv3_q  <= {w2_q[3], w2_q[2]};
      vec4_q <= vec4_d;
      cr5_q  <= cr5_d;
      pos5_q <= vec4_q[0];
      mag6_q <= mag6_d;
      for (int k = 0; k < 3; k++) begin
        neg6_q[k] <= cr5_q[k][34];
      end
      or6_q   <= mag6_d[0] | mag6_d[1] | mag6_d[2];
      pos6_q  <= pos5_q;
      lead7_q <= lead7_d;
      zero7_q <= (or6_q == '0);
      mag7_q  <= mag6_q;
      neg7_q  <= neg6_q;
      pos7_q  <= pos6_q;
      nm8_q   <= nm8_d;
      tag8_q  <= '{pos: pos7_q, neg: neg7_q, zero: zero7_q};
      sqr9_q  <= sqr9_d;
      nm9_q   <= nm8_q;
      tag9_q  <= tag8_q;
      for (int i = 0; i <= SqSteps; i++) begin
        sq_rem_q[i] <= sq_rem_d[i];
        sq_res_q[i] <= sq_res_d[i];
      end
      sq_nm_q[0]  <= nm9_q;
      sq_tag_q[0] <= tag9_q;
      for (int i = 1; i <= SqSteps; i++) begin
        sq_nm_q[i]  <= sq_nm_q[i-1];
        sq_tag_q[i] <= sq_tag_q[i-1];
      end
      for (int j = 0; j <= DivSteps; j++) begin
        dv_rem_q[j] <= dv_rem_d[j];
        dv_quo_q[j] <= dv_quo_d[j];
      end
      for (int k = 0; k < 3; k++) begin
        dv_num_q[0][k] <= dv_n0[k][15:0];
      end
      dv_len_q[0] <= sq_res_q[SqSteps][31:0];
      dv_tag_q[0] <= sq_tag_q[SqSteps];
      for (int j = 1; j <= DivSteps; j++) begin
        dv_num_q[j] <= dv_num_q[j-1];
        dv_len_q[j] <= dv_len_q[j-1];
        dv_tag_q[j] <= dv_tag_q[j-1];
      end
      if (dv_vld_q[DivSteps]) begin
        out_pos_q <= dv_tag_q[DivSteps].pos;
        out_nrm_q <= out_nrm_d;
        out_nv_q  <= !dv_tag_q[DivSteps].zero;
      end
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.pos_x        = out_pos_q[0];
  assign rsp_o.pos_y        = out_pos_q[1];
  assign rsp_o.pos_z        = out_pos_q[2];
  assign rsp_o.normal_x     = out_nrm_q[0];
  assign rsp_o.normal_y     = out_nrm_q[1];
  assign rsp_o.normal_z     = out_nrm_q[2];
  assign rsp_o.normal_valid = out_nv_q;

endmodule

/* sv/biquadratic_bezier_surface_eval.sv */
// Biquadratic Bezier patch evaluator.
// The request channel carries one word per item. A load word writes one of the
// nine control points; an evaluate word carries (u, v) and returns one response
// word with the surface point and its unit normal. Loads return nothing, and a
// load to a slot beyond the grid is taken and dropped.
// The configuration channel writes the neighbour step; it is always ready.
// Throughput is one word per cycle while the receiver keeps ready high. The
// bit-serial square root (32 stages) and the bit-serial divider (16 stages)
// lie behind the queue, blend and cross-product stages. Words flow through a
// short queue into the back pipeline, so loads and evaluations keep their
// order and each evaluation sees every earlier load. When the receiver holds
// ready low with a word in the output register, that register and the whole
// back pipeline hold; the queue then fills and request ready falls.
// Reset restores the default patch and a step of 55, and empties the pipeline.
module biquadratic_bezier_surface_eval #(
  parameter int unsigned QueueDepth = bbse_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbse_cfg_if.sink    cfg_i,
  bbse_in_if.sink     req_i,
  bbse_out_if.source  rsp_o
);
  import bbse_pkg::*;

  item_t push_item, pop_item;
  logic  push, pop, full, empty;

  // Front: step register, parameter clamping and neighbour parameters.
  bbse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // Queue that lets the front keep taking words while the back stalls.
  bbse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  // Back: control point store and the evaluation pipeline.
  bbse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (pop_item),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

/* bench/tb.sv */
module tb;
  import bbse_pkg::*;

  // One response word as it leaves the block, also used for the expectations.
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               normal_valid;
  } surf_word_t;

  // Cycles with no accepted word before the run is declared hung.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned HoldCycles = 300;

  // The scoreboard keeps its own copy of the patch and the step. Accepted loads
  // on the grid update that copy; evaluations queue their surface words.
  class patch_scoreboard;
    int          grid[9][3];
    int          step;
    surf_word_t  pending_q[$];
    int          errors;

    function void reset_patch();
      point_t p;
      for (int i = 0; i < 9; i++) begin
        p = default_point(4'(i));
        for (int k = 0; k < 3; k++) grid[i][k] = int'($signed(p[k]));
      end
      step = int'(StepReset);
      errors = 0;
    endfunction

    // Quadratic Bernstein blend with Q2.30 weights, rounded half up to Q4.12.
    function int bernstein(int a, int b, int c, int t);
      longint omt, tt, acc;
      omt = 64'sd32768 - t;
      tt = t;
      acc = omt * omt * a + 2 * omt * tt * b + tt * tt * c + (64'sd1 <<< 29);
      return int'(acc >>> 30);
    endfunction

    // Rows blended in u first, then the three row results in v.
    function void patch_point(int u, int v, output int pt[3]);
      int row[3];
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++)
          row[r] = bernstein(grid[r*3][k], grid[r*3+1][k], grid[r*3+2][k], u);
        pt[k] = bernstein(row[0], row[1], row[2], v);
      end
    endfunction

    function bit [63:0] root_floor(bit [63:0] s);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_word(logic op, logic [3:0] idx, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z,
                            logic [15:0] u_in, logic [15:0] v_in);
      int u, v, un, vn;
      int p[3], pu[3], pv[3];
      longint du[3], dv[3], cr[3];
      bit [63:0] mag[3], m, s, len, q;
      int n;
      surf_word_t w;
      if (op == OpLoad) begin
        // Loads beyond the grid are dropped by the block.
        if (idx <= MaxSlot) begin
          grid[idx][0] = x;
          grid[idx][1] = y;
          grid[idx][2] = z;
        end
        return;
      end
      u = (u_in > 16'd32768) ? 32768 : int'(u_in);
      v = (v_in > 16'd32768) ? 32768 : int'(v_in);
      un = (u + step > 32768) ? 32768 : u + step;
      vn = (v + step > 32768) ? 32768 : v + step;
      patch_point(u, v, p);
      patch_point(un, v, pu);
      patch_point(u, vn, pv);
      for (int k = 0; k < 3; k++) begin
        du[k] = pu[k] - p[k];
        dv[k] = pv[k] - p[k];
      end
      cr[0] = dv[1] * du[2] - dv[2] * du[1];
      cr[1] = dv[2] * du[0] - dv[0] * du[2];
      cr[2] = dv[0] * du[1] - dv[1] * du[0];
      w.pos_x = p[0][15:0];
      w.pos_y = p[1][15:0];
      w.pos_z = p[2][15:0];
      m = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = (cr[k] < 0) ? -cr[k] : cr[k];
        if (mag[k] > m) m = mag[k];
      end
      if (m == 0) begin
        // A flat neighbourhood gives no direction at all.
        w.normal_x = '0;
        w.normal_y = '0;
        w.normal_z = '0;
        w.normal_valid = 1'b0;
      end else begin
        while (m >= (64'd1 << 31)) begin
          m >>= 1;
          for (int j = 0; j < 3; j++) mag[j] >>= 1;
        end
        while (m < (64'd1 << 30)) begin
          m <<= 1;
          for (int j = 0; j < 3; j++) mag[j] <<= 1;
        end
        s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = root_floor(s);
        for (int k = 0; k < 3; k++) begin
          q = (mag[k] * 64'd16384 + len / 2) / len;
          n = (cr[k] < 0) ? -int'(q) : int'(q);
          if (k == 0) w.normal_x = n[15:0];
          else if (k == 1) w.normal_y = n[15:0];
          else w.normal_z = n[15:0];
        end
        w.normal_valid = 1'b1;
      end
      pending_q = {pending_q, w};
    endfunction

    function void check_word(surf_word_t got);
      surf_word_t exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected surface word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.pos_x !== exp_w.pos_x)
        $display("%0t: pos_x expected %0d got %0d", $time, exp_w.pos_x, got.pos_x);
      if (got.pos_y !== exp_w.pos_y)
        $display("%0t: pos_y expected %0d got %0d", $time, exp_w.pos_y, got.pos_y);
      if (got.pos_z !== exp_w.pos_z)
        $display("%0t: pos_z expected %0d got %0d", $time, exp_w.pos_z, got.pos_z);
      if (got.normal_x !== exp_w.normal_x)
        $display("%0t: normal_x expected %0d got %0d", $time, exp_w.normal_x,
                 got.normal_x);
      if (got.normal_y !== exp_w.normal_y)
        $display("%0t: normal_y expected %0d got %0d", $time, exp_w.normal_y,
                 got.normal_y);
      if (got.normal_z !== exp_w.normal_z)
        $display("%0t: normal_z expected %0d got %0d", $time, exp_w.normal_z,
                 got.normal_z);
      if (got.normal_valid !== exp_w.normal_valid)
        $display("%0t: normal_valid expected %0b got %0b", $time,
                 exp_w.normal_valid, got.normal_valid);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bbse_cfg_if cfg_if ();
  bbse_in_if  req_if ();
  bbse_out_if rsp_if ();

  biquadratic_bezier_surface_eval i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  patch_scoreboard board;

  // Switches shared by the driving processes. The sender and the receiver
  // idle at random only while idle_on is set; hold_req asks the receiver for
  // one long hold-off, which it counts out itself.
  bit idle_on;
  bit hold_req;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver changes ready at the falling edge only.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rsp_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      rsp_if.ready = idle_on ? ($urandom_range(0, 99) >= 30) : 1'b1;
    end
  end

  // Responses are checked at the rising edge at which they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      board.check_word({rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z, rsp_if.normal_x,
                        rsp_if.normal_y, rsp_if.normal_z, rsp_if.normal_valid});
  end

  // The watchdog restarts whenever a word moves on any channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offers one request word, holding it until the block takes it. The word is
  // noted by the scoreboard at the edge of acceptance.
  task automatic send_word(logic op, logic [3:0] idx, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z, logic [15:0] u,
                           logic [15:0] v);
    if (idle_on && $urandom_range(0, 99) < 30) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.opcode = op;
    req_if.point_index = idx;
    req_if.coord_x = x;
    req_if.coord_y = y;
    req_if.coord_z = z;
    req_if.u_param = u;
    req_if.v_param = v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_word(op, idx, x, y, z, u, v);
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic load_point(logic [3:0] idx, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
    send_word(OpLoad, idx, x, y, z, 16'($urandom), 16'($urandom));
  endtask

  task automatic eval_at(logic [15:0] u, logic [15:0] v);
    send_word(OpEval, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), u, v);
  endtask

  // Waits until every expected word has arrived and the pipeline has had time
  // to finish any trailing loads.
  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_step(logic [15:0] value);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.step_size = value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.step = int'(value);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Parameters mostly lie within the patch, with the ends and some out-of-range
  // values mixed in so that every bit toggles.
  function automatic logic [15:0] pick_param();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 16) return 16'd32768;
    if (r < 26) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(0, 32768));
  endfunction

  // Coordinates are mostly moderate so that the surface stays well shaped.
  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  // Random traffic: mostly evaluations, with a sprinkling of loads, some of
  // them to slots beyond the grid.
  task automatic random_burst(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 18)
        load_point(4'($urandom_range(0, 15)), pick_coord(), pick_coord(), pick_coord());
      else
        eval_at(pick_param(), pick_param());
    end
  endtask

  initial begin
    logic [15:0] steps[6];
    board = new();
    board.reset_patch();
    idle_on = 1'b1;
    hold_req = 1'b0;
    quiet_cycles = 0;
    cfg_if.valid = 1'b0;
    cfg_if.step_size = '0;
    req_if.valid = 1'b0;
    req_if.opcode = OpLoad;
    req_if.point_index = '0;
    req_if.coord_x = '0;
    req_if.coord_y = '0;
    req_if.coord_z = '0;
    req_if.u_param = '0;
    req_if.v_param = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part on the default patch: corners, centre, and parameters
    // above one which must be clamped to the edge of the patch.
    eval_at(16'd0, 16'd0);
    eval_at(16'd32768, 16'd32768);
    eval_at(16'd16384, 16'd16384);
    eval_at(16'd32768, 16'd0);
    eval_at(16'hFFFF, 16'd1);
    eval_at(16'd32767, 16'hFFFF);
    // Loads to slots past the grid must leave the patch alone.
    load_point(4'd9, 16'h7FFF, 16'h8000, 16'h7FFF);
    load_point(4'd15, 16'h8000, 16'h7FFF, 16'h8000);
    eval_at(16'd20000, 16'd9000);
    // Extreme coordinates in a corner slot and the centre slot.
    load_point(4'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
    load_point(4'd4, 16'h8000, 16'h7FFF, 16'h8000);
    eval_at(16'd0, 16'd0);
    eval_at(16'd16384, 16'd16384);
    // A flat grid of equal points has no normal.
    for (int i = 0; i < 9; i++) load_point(4'(i), 16'h0123, 16'hFEDC, 16'h0400);
    eval_at(16'd10000, 16'd30000);
    eval_at(16'd32768, 16'd32768);

    // Random phases, each under its own step, including zero, the smallest,
    // one whole unit and the largest code.
    steps[0] = StepReset;
    steps[1] = 16'd1;
    steps[2] = 16'd32768;
    steps[3] = 16'd0;
    steps[4] = 16'hFFFF;
    steps[5] = 16'($urandom_range(2, 4000));
    for (int ph = 0; ph < 6; ph++) begin
      write_step(steps[ph]);
      // A fresh, random but sensible patch for each phase.
      for (int i = 0; i < 9; i++) load_point(4'(i), pick_coord(), pick_coord(), pick_coord());
      // One phase runs without any idling at all.
      idle_on = (ph != 4);
      // In one phase the receiver stops for a long while, so that the queue
      // fills and request ready falls, while the sender keeps offering words.
      if (ph == 1) hold_req = 1'b1;
      random_burst(60);
      // Halfway the sender waits for every outstanding word to come back.
      drain();
      random_burst(60);
    end
    idle_on = 1'b1;

    drain();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
